// File: hdl/ntc_pkg.sv
// ntc_pkg: shared constants and codes for the ntc beta temperature converter
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package ntc_pkg;

  localparam int ADC_BITS      = 12;
  localparam int LOG_FRAC_BITS = 16;

  localparam int RES_BITS      = 24;
  localparam int BETA_BITS     = 14;
  localparam int T0_BITS       = 16;
  localparam int TEMP_BITS     = 16;
  localparam int STATUS_BITS   = 2;
  localparam int CFG_DATA_BITS = 24;
  localparam int CFG_IDX_BITS  = 3;

  // normalized mantissa in q30, value in [1,2)
  localparam int MANT_W = 31;
  // quotient bits kept by the divider; anything wider saturates
  localparam int Q_W    = 16;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam int ZERO_C_CK = 27315;
  localparam int TEMP_MAX  = 32767;
  localparam int TC_MAX    = TEMP_MAX + ZERO_C_CK;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FULL_SCALE = 3'd0,
    REG_FIXED_RES  = 3'd1,
    REG_NOM_RES    = 3'd2,
    REG_BETA       = 3'd3,
    REG_NOM_TEMP   = 3'd4
  } cfg_reg_t;

  localparam logic [STATUS_BITS-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] STAT_OPEN  = 2'd1;
  localparam logic [STATUS_BITS-1:0] STAT_SHORT = 2'd2;
  localparam logic [STATUS_BITS-1:0] STAT_SAT   = 2'd3;

endpackage

`default_nettype wire

// File: hdl/ntc_in_if.sv
// ntc_in_if: valid/ready channel carrying one adc sample
// depends on ntc_pkg
`default_nettype none

interface ntc_in_if;
  import ntc_pkg::*;

  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] adc_code;

  modport source (output valid, output adc_code, input ready);
  modport sink   (input valid, input adc_code, output ready);
endinterface

`default_nettype wire

// File: hdl/ntc_out_if.sv
// ntc_out_if: valid/ready channel carrying one temperature result
// depends on ntc_pkg
`default_nettype none

interface ntc_out_if;
  import ntc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [TEMP_BITS-1:0]   temp_centi_celsius;
  logic [STATUS_BITS-1:0] status;

  modport source (output valid, output temp_centi_celsius, output status, input ready);
  modport sink   (input valid, input temp_centi_celsius, input status, output ready);
endinterface

`default_nettype wire

// File: hdl/ntc_beta_temperature_convert.sv
// ntc_beta_temperature_convert: adc code to centi-celsius via the beta equation
// one sample per cycle while out_ch.ready does not stall the output stage
// the squaring log2 stages (one fraction bit each) and the restoring divider
// (one quotient bit each) set the depth
// each stage holds its item only while the next one is full and stalled
// rst is synchronous: clears valid bits and loads register reset values
`default_nettype none

module ntc_beta_temperature_convert (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_we,
  input  wire [ntc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire [ntc_pkg::CFG_DATA_BITS-1:0] cfg_data,
  ntc_in_if.sink                           in_ch,
  ntc_out_if.source                        out_ch
);
  import ntc_pkg::*;

  localparam int X_W    = RES_BITS + ADC_BITS;
  localparam int P_W    = $clog2(X_W);
  localparam int LOG_W  = P_W + LOG_FRAC_BITS;
  localparam int PROD_W = LOG_W + 32;
  localparam int TL_W   = T0_BITS + 1 + LOG_W + 1;
  localparam int DEN_W  = TL_W + 1;
  localparam int DU_W   = DEN_W - 1;
  localparam int T1_W   = BETA_BITS + 7 + LOG_FRAC_BITS;
  localparam int BT_W   = BETA_BITS + T0_BITS;
  localparam int NUM_W  = BT_W + 7 + LOG_FRAC_BITS;
  localparam int N_W    = ((NUM_W > DU_W) ? NUM_W : DU_W) + 1;
  localparam int R_W    = ((N_W > DU_W + Q_W) ? N_W : DU_W + Q_W);

  localparam int ST_MUL   = 0;
  localparam int ST_NORM  = 1;
  localparam int ST_DIFF  = ST_NORM + LOG_FRAC_BITS + 1;
  localparam int ST_LNMUL = ST_DIFF + 1;
  localparam int ST_LNRND = ST_LNMUL + 1;
  localparam int ST_T0MUL = ST_LNRND + 1;
  localparam int ST_DEN   = ST_T0MUL + 1;
  localparam int ST_NUM   = ST_DEN + 1;
  localparam int ST_OVF   = ST_NUM + 1;
  localparam int ST_OUT   = ST_OVF + Q_W + 1;
  localparam int NS       = ST_OUT + 1;

  // configuration registers
  logic [ADC_BITS-1:0]  full_scale;
  logic [RES_BITS-1:0]  fixed_res;
  logic [RES_BITS-1:0]  nom_res;
  logic [BETA_BITS-1:0] beta;
  logic [T0_BITS-1:0]   nom_temp;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale <= ADC_BITS'(4095);
      fixed_res  <= RES_BITS'(10000);
      nom_res    <= RES_BITS'(10000);
      beta       <= BETA_BITS'(3950);
      nom_temp   <= T0_BITS'(29815);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FULL_SCALE: full_scale <= cfg_data[ADC_BITS-1:0];
        REG_FIXED_RES:  fixed_res  <= cfg_data[RES_BITS-1:0];
        REG_NOM_RES:    nom_res    <= cfg_data[RES_BITS-1:0];
        REG_BETA:       beta       <= cfg_data[BETA_BITS-1:0];
        REG_NOM_TEMP:   nom_temp   <= cfg_data[T0_BITS-1:0];
        default: ;
      endcase
    end
  end

  // terms that follow from configuration alone, refreshed every cycle
  logic [T1_W-1:0]  term_b;
  logic [BT_W-1:0]  bt0;
  logic [NUM_W-1:0] num_c;

  always_ff @(posedge clk) begin
    term_b <= T1_W'(beta * 7'd100) << LOG_FRAC_BITS;
    bt0    <= BT_W'(beta * nom_temp);
    num_c  <= NUM_W'(bt0 * 7'd100) << LOG_FRAC_BITS;
  end

  // stage handshake: a stage takes new data when empty or when it moves on
  logic [NS-1:0] v;
  logic [NS-1:0] en;
  logic [NS-1:0] v_in;

  always_comb begin
    en[NS-1] = !v[NS-1] || out_ch.ready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign v_in = {v[NS-2:0], in_ch.valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (en[i]) begin
          v[i] <= v_in[i];
        end
      end
    end
  end

  assign in_ch.ready = en[0] && !rst;

  // status travels with every item
  logic [STATUS_BITS-1:0] st    [NS];
  logic [STATUS_BITS-1:0] st_in [NS];

  always_ff @(posedge clk) begin
    for (int i = 0; i < NS; i++) begin
      if (en[i]) begin
        st[i] <= st_in[i];
      end
    end
  end

  // stage 0: divider products x = rf*(full-code), y = code*r25
  logic [RES_BITS-1:0] rf_eff;
  logic [RES_BITS-1:0] r25_eff;
  logic [X_W-1:0]      x0;
  logic [X_W-1:0]      y0;

  assign rf_eff  = (fixed_res == '0) ? RES_BITS'(1) : fixed_res;
  assign r25_eff = (nom_res == '0) ? RES_BITS'(1) : nom_res;

  always_ff @(posedge clk) begin
    if (en[ST_MUL]) begin
      x0 <= X_W'(rf_eff * (full_scale - in_ch.adc_code));
      y0 <= X_W'(in_ch.adc_code * r25_eff);
    end
  end

  // stage 1: top set bit and q30 mantissa
  logic [P_W-1:0]    sq_px [LOG_FRAC_BITS+1];
  logic [P_W-1:0]    sq_py [LOG_FRAC_BITS+1];
  logic [MANT_W-1:0] sq_mx [LOG_FRAC_BITS+1];
  logic [MANT_W-1:0] sq_my [LOG_FRAC_BITS+1];
  logic [LOG_FRAC_BITS-1:0] sq_fx [LOG_FRAC_BITS+1];
  logic [LOG_FRAC_BITS-1:0] sq_fy [LOG_FRAC_BITS+1];

  logic [P_W-1:0] px_c;
  logic [P_W-1:0] py_c;

  always_comb begin
    px_c = '0;
    py_c = '0;
    for (int i = 0; i < X_W; i++) begin
      if (x0[i]) px_c = P_W'(i);
      if (y0[i]) py_c = P_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_NORM]) begin
      sq_px[0] <= px_c;
      sq_py[0] <= py_c;
      sq_mx[0] <= MANT_W'({x0, {(MANT_W-1){1'b0}}} >> px_c);
      sq_my[0] <= MANT_W'({y0, {(MANT_W-1){1'b0}}} >> py_c);
      sq_fx[0] <= '0;
      sq_fy[0] <= '0;
    end
  end

  // squaring stages: each yields one fraction bit of log2
  for (genvar k = 1; k <= LOG_FRAC_BITS; k++) begin : g_sq
    logic [2*MANT_W-1:0] sqx;
    logic [2*MANT_W-1:0] sqy;
    logic [MANT_W:0]     hx;
    logic [MANT_W:0]     hy;

    assign sqx = sq_mx[k-1] * sq_mx[k-1];
    assign sqy = sq_my[k-1] * sq_my[k-1];
    assign hx  = sqx[2*MANT_W-1:MANT_W-1];
    assign hy  = sqy[2*MANT_W-1:MANT_W-1];

    always_ff @(posedge clk) begin
      if (en[ST_NORM+k]) begin
        sq_px[k] <= sq_px[k-1];
        sq_py[k] <= sq_py[k-1];
        sq_mx[k] <= hx[MANT_W] ? hx[MANT_W:1] : hx[MANT_W-1:0];
        sq_my[k] <= hy[MANT_W] ? hy[MANT_W:1] : hy[MANT_W-1:0];
        sq_fx[k] <= {sq_fx[k-1][LOG_FRAC_BITS-2:0], hx[MANT_W]};
        sq_fy[k] <= {sq_fy[k-1][LOG_FRAC_BITS-2:0], hy[MANT_W]};
      end
    end
  end

  // log2 difference, magnitude and sign
  logic [LOG_W:0]   d_c;
  logic [LOG_W-1:0] mag;
  logic             neg_d;

  assign d_c = {1'b0, sq_px[LOG_FRAC_BITS], sq_fx[LOG_FRAC_BITS]}
             - {1'b0, sq_py[LOG_FRAC_BITS], sq_fy[LOG_FRAC_BITS]};

  always_ff @(posedge clk) begin
    if (en[ST_DIFF]) begin
      neg_d <= d_c[LOG_W];
      mag   <= d_c[LOG_W] ? LOG_W'(-d_c) : d_c[LOG_W-1:0];
    end
  end

  // ln = log2 * ln2, rounded half away from zero
  logic [PROD_W-1:0] ln_prod;
  logic              neg_p;
  logic [PROD_W:0]   ln_rnd;
  logic [LOG_W-1:0]  ln_mag;
  logic signed [LOG_W:0] lnq;

  always_ff @(posedge clk) begin
    if (en[ST_LNMUL]) begin
      ln_prod <= PROD_W'(mag * LN2_Q32);
      neg_p   <= neg_d;
    end
  end

  assign ln_rnd = {1'b0, ln_prod} + (PROD_W+1)'(64'd1 << 31);
  assign ln_mag = ln_rnd[32 +: LOG_W];

  always_ff @(posedge clk) begin
    if (en[ST_LNRND]) begin
      lnq <= neg_p ? -$signed({1'b0, ln_mag}) : $signed({1'b0, ln_mag});
    end
  end

  // den = 100*b*2^f + t0*ln
  logic signed [TL_W-1:0]  tl;
  logic signed [DEN_W-1:0] den;
  logic                    den_pos;
  logic [DU_W-1:0]         den_u;

  always_ff @(posedge clk) begin
    if (en[ST_T0MUL]) begin
      tl <= $signed({1'b0, nom_temp}) * lnq;
    end
    if (en[ST_DEN]) begin
      den <= DEN_W'(tl) + $signed({1'b0, DU_W'(term_b)});
    end
  end

  assign den_pos = !den[DEN_W-1] && (den != '0);
  assign den_u   = den[DU_W-1:0];

  // rounded dividend and overflow check against 2^Q_W quotient
  logic [R_W-1:0]  n_rnd;
  logic [DU_W-1:0] den_n;

  always_ff @(posedge clk) begin
    if (en[ST_NUM]) begin
      n_rnd <= R_W'(num_c) + R_W'(den_u >> 1);
      den_n <= den_u;
    end
  end

  logic [R_W-1:0]  dv_rem [Q_W+1];
  logic [DU_W-1:0] dv_den [Q_W+1];
  logic [Q_W-1:0]  dv_q   [Q_W+1];
  logic            dv_ovf [Q_W+1];

  always_ff @(posedge clk) begin
    if (en[ST_OVF]) begin
      dv_rem[0] <= n_rnd;
      dv_den[0] <= den_n;
      dv_q[0]   <= '0;
      dv_ovf[0] <= n_rnd >= (R_W'(den_n) << Q_W);
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 1; k <= Q_W; k++) begin : g_div
    logic [R_W-1:0] trial;
    logic           ge;

    assign trial = R_W'(dv_den[k-1]) << (Q_W - k);
    assign ge    = dv_rem[k-1] >= trial;

    always_ff @(posedge clk) begin
      if (en[ST_OVF+k]) begin
        dv_rem[k] <= ge ? dv_rem[k-1] - trial : dv_rem[k-1];
        dv_den[k] <= dv_den[k-1];
        dv_q[k]   <= {dv_q[k-1][Q_W-2:0], ge};
        dv_ovf[k] <= dv_ovf[k-1];
      end
    end
  end

  // status updates and the final temperature
  logic [Q_W:0]           tc_off;
  logic [TEMP_BITS-1:0]   temp_out;

  always_comb begin
    st_in[0] = (in_ch.adc_code == '0)        ? STAT_OPEN
             : (in_ch.adc_code >= full_scale) ? STAT_SHORT : STAT_OK;
    for (int i = 1; i < NS; i++) begin
      st_in[i] = st[i-1];
    end
    if (st[ST_DEN] == STAT_OK && !den_pos) begin
      st_in[ST_NUM] = STAT_SAT;
    end
    if (st[ST_OUT-1] == STAT_OK &&
        (dv_ovf[Q_W] || dv_q[Q_W] > Q_W'(TC_MAX))) begin
      st_in[ST_OUT] = STAT_SAT;
    end
  end

  assign tc_off = {1'b0, dv_q[Q_W]} - (Q_W+1)'(ZERO_C_CK);

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      unique case (st_in[ST_OUT])
        STAT_OK:  temp_out <= tc_off[TEMP_BITS-1:0];
        STAT_SAT: temp_out <= TEMP_BITS'(TEMP_MAX);
        default:  temp_out <= TEMP_BITS'(-ZERO_C_CK);
      endcase
    end
  end

  assign out_ch.valid              = v[ST_OUT];
  assign out_ch.temp_centi_celsius = temp_out;
  assign out_ch.status             = st[ST_OUT];

endmodule

`default_nettype wire
